[design/pfdc_pkg.sv]
package pfdc_pkg;

	// Bit positions in the class/flag word
	localparam int unsigned FLAG_RGB     = 0;
	localparam int unsigned FLAG_ALPHA   = 1;
	localparam int unsigned FLAG_LUM     = 2;
	localparam int unsigned FLAG_INDEXED = 3;
	localparam int unsigned FLAG_PREMUL  = 4;
	localparam int unsigned FLAG_BSWAP   = 5;
	localparam int unsigned FLAG_ALIGNED = 6;
	localparam int unsigned FLAG_UNDEF   = 7;

	localparam int unsigned NUM_COMP      = 4;
	localparam int unsigned COMP_ALPHA    = 3;
	localparam logic [7:0]  COMP_SIZE_MAX = 8'd16;
	localparam logic [7:0]  BYTE_SIZE     = 8'd8;
	localparam logic [5:0]  INDEXED_DEPTH_MAX = 6'd8;

	// Class codes in the low four flag bits
	localparam logic [3:0] CLASS_RGB       = 4'h1;
	localparam logic [3:0] CLASS_ALPHA     = 4'h2;
	localparam logic [3:0] CLASS_RGBA      = 4'h3;
	localparam logic [3:0] CLASS_LUM       = 4'h4;
	localparam logic [3:0] CLASS_LUM_ALPHA = 4'h6;

	// Required-component masks, bit i for component i (R, G, B, A)
	localparam logic [3:0] REQ_NONE = 4'h0;
	localparam logic [3:0] REQ_RGB  = 4'h7;
	localparam logic [3:0] REQ_A    = 4'h8;
	localparam logic [3:0] REQ_RGBA = 4'hF;

	typedef struct packed {
		logic [5:0] depth;
		logic [5:0] class_flags;
		logic       has_palette;
		logic [7:0] red_size;
		logic [7:0] green_size;
		logic [7:0] blue_size;
		logic [7:0] alpha_size;
		logic [7:0] red_shift;
		logic [7:0] green_shift;
		logic [7:0] blue_shift;
		logic [7:0] alpha_shift;
	} desc_t;

	typedef struct packed {
		logic       ok;
		logic [7:0] flags_out;
		logic [7:0] red_shift_out;
		logic [7:0] green_shift_out;
		logic [7:0] blue_shift_out;
		logic [7:0] alpha_shift_out;
	} res_t;

endpackage

[design/pixel_format_descriptor_check_unit.sv]
// Checks one packed-pixel format descriptor per transfer and returns the
// verdict, the normalised flag word and the shifts after byte-swap folding.
// An accepted descriptor is captured in the single input register feeding the
// check logic, and its result in the output register after it; one descriptor
// is taken every cycle unless the input is stalled.
// A stalled output holds its result and back-pressure reaches the input
// only when both registers are full.
module pixel_format_descriptor_check_unit
	import pfdc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  desc_valid,
	output logic  desc_stall,
	input  desc_t desc,
	output logic  res_valid,
	input  logic  res_stall,
	output res_t  res
);

	logic  valid_s1;
	desc_t desc_s1;
	res_t  res_comb;
	logic  adv_s2;

	assign adv_s2     = valid_s1 && (!res_valid || !res_stall);
	assign desc_stall = valid_s1 && !adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!desc_stall) begin
			valid_s1 <= desc_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (desc_valid && !desc_stall) begin
			desc_s1 <= desc;
		end
	end

	pfdc_check u_check (
		.desc (desc_s1),
		.res  (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (!res_valid || !res_stall) begin
			res_valid <= valid_s1;
		end
	end

	// hold the result while the consumer stalls
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			res <= res_comb;
		end
	end

	a_no_drop_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s2 |=> valid_s1)
		else $error("held descriptor dropped");

	a_invalid_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.ok |-> res.flags_out[FLAG_ALIGNED] == 1'b0 &&
			res.flags_out[FLAG_UNDEF] == 1'b0)
		else $error("computed flags on invalid result");

	a_indexed_flags: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.ok && res.flags_out[FLAG_INDEXED] |->
			res.flags_out[FLAG_ALIGNED] && !res.flags_out[FLAG_UNDEF] &&
			!res.flags_out[FLAG_BSWAP])
		else $error("indexed format flags wrong");

	a_premul_needs_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.ok && !res.flags_out[FLAG_INDEXED] &&
			!res.flags_out[FLAG_ALPHA] |-> !res.flags_out[FLAG_PREMUL])
		else $error("premultiplied kept without alpha");

endmodule

[design/pfdc_check.sv]
module pfdc_check
	import pfdc_pkg::*;
(
	input  desc_t desc,
	output res_t  res
);

	logic [7:0]  sz [NUM_COMP];
	logic [7:0]  sh [NUM_COMP];
	logic [7:0]  sh_fold [NUM_COMP];
	logic [31:0] mask [NUM_COMP];
	logic [3:0]  present, bad, unal, straddle;
	logic [3:0]  req;
	logic [31:0] combined, depth_mask;
	logic        depth_ok, overlap_rgb, alpha_ovl, lum, lum_neq;
	logic        valid_idx, valid_comp, ok, indexed, fold;
	logic [7:0]  fl;

	assign sz[0] = desc.red_size;
	assign sz[1] = desc.green_size;
	assign sz[2] = desc.blue_size;
	assign sz[3] = desc.alpha_size;
	assign sh[0] = desc.red_shift;
	assign sh[1] = desc.green_shift;
	assign sh[2] = desc.blue_shift;
	assign sh[3] = desc.alpha_shift;

	always_comb begin
		case (desc.depth)
			6'd1, 6'd2, 6'd4, 6'd8, 6'd16, 6'd24, 6'd32: depth_ok = 1'b1;
			default: depth_ok = 1'b0;
		endcase
	end

	always_comb begin
		case (desc.class_flags[3:0])
			CLASS_RGB:       req = REQ_RGB;
			CLASS_ALPHA:     req = REQ_A;
			CLASS_RGBA:      req = REQ_RGBA;
			CLASS_LUM:       req = REQ_RGB;
			CLASS_LUM_ALPHA: req = REQ_RGBA;
			default:         req = REQ_NONE;
		endcase
	end

	for (genvar i = 0; i < NUM_COMP; i++) begin : g_comp
		logic [8:0]  sum;
		logic [8:0]  last;
		logic [31:0] low_bits;
		assign sum      = {1'b0, sh[i]} + {1'b0, sz[i]};
		assign last     = sum - 9'd1;
		assign present[i] = sz[i] != 8'd0;
		assign bad[i]   = present[i]
			? (!req[i] || sz[i] > COMP_SIZE_MAX || sum > {3'b0, desc.depth})
			: (req[i] || sh[i] != 8'd0);
		assign unal[i]  = present[i] && (sz[i] != BYTE_SIZE || sh[i][2:0] != 3'd0);
		assign straddle[i] = present[i] && ({1'b0, sh[i][7:3]} != last[8:3]);
		// mask only matters once size and fit checks have passed
		assign low_bits = (32'd1 << sz[i][4:0]) - 32'd1;
		assign mask[i]  = present[i] ? (low_bits << sh[i][4:0]) : 32'd0;
		assign sh_fold[i] = present[i] ? (8'({2'b0, desc.depth}) - sh[i] - sz[i]) : sh[i];
	end

	assign combined    = mask[0] | mask[1] | mask[2] | mask[3];
	assign depth_mask  = desc.depth[5] ? '1 : ((32'd1 << desc.depth[4:0]) - 32'd1);
	assign overlap_rgb = |((mask[0] & mask[1]) | (mask[0] & mask[2]) | (mask[1] & mask[2]));
	assign alpha_ovl   = |(mask[COMP_ALPHA] & (mask[0] | mask[1] | mask[2]));
	assign lum         = desc.class_flags[FLAG_LUM];
	assign lum_neq     = lum && (sz[0] != sz[1] || sh[0] != sh[1] ||
		sz[1] != sz[2] || sh[1] != sh[2]);
	assign indexed     = desc.class_flags[FLAG_INDEXED];

	assign valid_idx  = desc.depth <= INDEXED_DEPTH_MAX && desc.has_palette;
	assign valid_comp = req != REQ_NONE && bad == 4'd0 && !alpha_ovl &&
		(lum == overlap_rgb) && !lum_neq;
	assign ok = depth_ok && (indexed ? valid_idx : valid_comp);

	// fold byte swap into shifts for non-indexed depths above a byte when nothing straddles a byte
	assign fold = desc.class_flags[FLAG_BSWAP] && !indexed &&
		desc.depth > BYTE_SIZE[5:0] && straddle == 4'd0;

	always_comb begin
		fl = {2'b00, desc.class_flags};
		if (!indexed && !desc.class_flags[FLAG_ALPHA])
			fl[FLAG_PREMUL] = 1'b0;
		if (desc.depth <= BYTE_SIZE[5:0] || fold)
			fl[FLAG_BSWAP] = 1'b0;
		fl[FLAG_ALIGNED] = indexed || unal == 4'd0;
		fl[FLAG_UNDEF]   = !indexed && combined != depth_mask;
	end

	always_comb begin
		res.ok              = ok;
		res.flags_out       = ok ? fl : {2'b00, desc.class_flags};
		res.red_shift_out   = (ok && fold) ? sh_fold[0] : sh[0];
		res.green_shift_out = (ok && fold) ? sh_fold[1] : sh[1];
		res.blue_shift_out  = (ok && fold) ? sh_fold[2] : sh[2];
		res.alpha_shift_out = (ok && fold) ? sh_fold[3] : sh[3];
	end

endmodule
